// ===== design/sssl_pkg.sv =====
// ----------------------------------------------------------------------------
// sssl_pkg
// Shared types, codes and constants of the sonar scan speed limiter.
// ----------------------------------------------------------------------------
package sssl_pkg;

    localparam int SCAN_POINTS_DEF = 4;

    localparam int ACTION_W = 2;
    localparam int PHASE_W  = 4;
    localparam int DATA_W   = 8;
    localparam int CFG_IDX_W = 3;

    // item actions
    localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ENABLE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DISABLE = 2'd2;

    // scan machine phases
    localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
    localparam logic [PHASE_W-1:0] PH_POSITION  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT_STOP = 4'd2;
    localparam logic [PHASE_W-1:0] PH_PING      = 4'd3;
    localparam logic [PHASE_W-1:0] PH_WAIT_ECHO = 4'd4;
    localparam logic [PHASE_W-1:0] PH_CALC      = 4'd5;
    localparam logic [PHASE_W-1:0] PH_REACT     = 4'd6;
    localparam logic [PHASE_W-1:0] PH_PARK      = 4'd7;
    localparam logic [PHASE_W-1:0] PH_WAIT_PARK = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_MID     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LOWEST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LOWER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX    = 3'd5;

    localparam logic [DATA_W-1:0] RST_DIST_MIN     = 8'd10;
    localparam logic [DATA_W-1:0] RST_DIST_MID     = 8'd20;
    localparam logic [DATA_W-1:0] RST_DIST_MAX     = 8'd40;
    localparam logic [DATA_W-1:0] RST_SPEED_LOWEST = 8'd60;
    localparam logic [DATA_W-1:0] RST_SPEED_LOWER  = 8'd120;
    localparam logic [DATA_W-1:0] RST_RANGE_MAX    = 8'd200;

    // scan angle table, repeats every four points
    function automatic logic [DATA_W-1:0] angle_of(input logic [1:0] sel);
        logic [DATA_W-1:0] ang;
        case (sel)
            2'd0: ang = 8'd90;
            2'd1: ang = 8'd120;
            2'd2: ang = 8'd90;
            2'd3: ang = 8'd60;
            default: ang = 8'd90;
        endcase
        return ang;
    endfunction

    typedef struct packed {
        logic capture;
        logic commit;
        logic scan_init;
        logic scan_step;
        logic scan_commit;
    } dp_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } dp_sts_t;

endpackage

// ===== design/sonar_scan_speed_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// sonar_scan_speed_limiter_unit
// Obstacle-scan sequencer with tiered motor speed limit.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    action, servo/echo status, limit
//   m_       out        m_valid/m_ready    servo, ping and speed commands
//   cfg_     in         cfg_wr_en          cfg_index, cfg_data
//
// An ordinary item passes from accept through the execute state to the result
// register; a tick in the calculation phase also runs the nearest search,
// which compares one stored distance per cycle.
// A new item is accepted while an earlier result still waits in the output
// register; a result loads only into an empty register or with m_ready high.
// Synchronous active-low reset restores the register defaults and clears the
// scan state and stored distances at once.
// ----------------------------------------------------------------------------
module sonar_scan_speed_limiter_unit
    import sssl_pkg::*;
#(
    parameter int SCAN_POINTS = SCAN_POINTS_DEF
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ACTION_W-1:0]  s_action,
    input  logic                 s_servo_settled,
    input  logic                 s_echo_ready,
    input  logic [DATA_W-1:0]    s_echo_distance,
    input  logic [DATA_W-1:0]    s_servo_angle,
    input  logic [DATA_W-1:0]    s_current_limit,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_servo_move,
    output logic [DATA_W-1:0]    m_servo_target,
    output logic                 m_ping_request,
    output logic                 m_speed_write,
    output logic [DATA_W-1:0]    m_speed_value,
    output logic                 m_speed_limited,
    output logic [DATA_W-1:0]    m_nearest,
    output logic [PHASE_W-1:0]   m_phase_now
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    sssl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sssl_dp #(
        .SCAN_POINTS (SCAN_POINTS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_action        (s_action),
        .s_servo_settled (s_servo_settled),
        .s_echo_ready    (s_echo_ready),
        .s_echo_distance (s_echo_distance),
        .s_servo_angle   (s_servo_angle),
        .s_current_limit (s_current_limit),
        .cmd             (cmd),
        .sts             (sts),
        .m_servo_move    (m_servo_move),
        .m_servo_target  (m_servo_target),
        .m_ping_request  (m_ping_request),
        .m_speed_write   (m_speed_write),
        .m_speed_value   (m_speed_value),
        .m_speed_limited (m_speed_limited),
        .m_nearest       (m_nearest),
        .m_phase_now     (m_phase_now)
    );

endmodule

// ===== design/sssl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sssl_ctrl
// Sequencer: accepts an item, runs the nearest search when needed and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module sssl_ctrl
    import sssl_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_FIN  = 4'b1000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.capture     = s_valid && (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.need_scan) begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end else if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.scan_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit || cmd.scan_commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_single_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.commit && cmd.scan_commit))
        else $error("two result loads in one cycle");

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit || cmd.scan_commit) |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending result");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted item not executed");

    a_fin_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_FIN) |-> $past(state_reg == ST_SCAN && sts.scan_last))
        else $error("search finished early");
`endif

endmodule

// ===== design/sssl_dp.sv =====
// ----------------------------------------------------------------------------
// sssl_dp
// Datapath: configuration, scan machine state, stored distances, nearest
// search and result registers.
// ----------------------------------------------------------------------------
module sssl_dp
    import sssl_pkg::*;
#(
    parameter int SCAN_POINTS = SCAN_POINTS_DEF
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic [ACTION_W-1:0]  s_action,
    input  logic                 s_servo_settled,
    input  logic                 s_echo_ready,
    input  logic [DATA_W-1:0]    s_echo_distance,
    input  logic [DATA_W-1:0]    s_servo_angle,
    input  logic [DATA_W-1:0]    s_current_limit,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts,
    output logic                 m_servo_move,
    output logic [DATA_W-1:0]    m_servo_target,
    output logic                 m_ping_request,
    output logic                 m_speed_write,
    output logic [DATA_W-1:0]    m_speed_value,
    output logic                 m_speed_limited,
    output logic [DATA_W-1:0]    m_nearest,
    output logic [PHASE_W-1:0]   m_phase_now
);

    localparam int IDX_W = (SCAN_POINTS > 1) ? $clog2(SCAN_POINTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_POINTS - 1);

    // configuration
    logic [DATA_W-1:0] dist_min_reg, dist_mid_reg, dist_max_reg;
    logic [DATA_W-1:0] speed_lowest_reg, speed_lower_reg, range_max_reg;

    // captured item
    logic [ACTION_W-1:0] act_reg;
    logic                settled_reg, echo_reg;
    logic [DATA_W-1:0]   echo_dist_reg, angle_reg, cur_reg;

    // scan state
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [IDX_W-1:0]   scan_index_reg, scan_index_next;
    logic               enabled_reg, enabled_next;
    logic [DATA_W-1:0]  nearest_reg;
    logic [DATA_W-1:0]  dist_reg [SCAN_POINTS];

    // nearest search
    logic [IDX_W-1:0]  scan_cnt_reg;
    logic [DATA_W-1:0] min_reg;
    logic [DATA_W-1:0] dist_rd;

    // step results
    logic              clear_dist, store_dist;
    logic              move_c, ping_c, wr_c, lim_c;
    logic [DATA_W-1:0] target_c, val_c;
    logic [3:0]        idx_ext;

    assign idx_ext = 4'(scan_index_reg);
    assign dist_rd = dist_reg[scan_cnt_reg];

    assign sts.need_scan = (act_reg == ACT_TICK) && (phase_reg == PH_CALC);
    assign sts.scan_last = (scan_cnt_reg == LAST_IDX);

    always_comb begin
        phase_next      = phase_reg;
        scan_index_next = scan_index_reg;
        enabled_next    = enabled_reg;
        clear_dist      = 1'b0;
        store_dist      = 1'b0;
        move_c          = 1'b0;
        target_c        = '0;
        ping_c          = 1'b0;
        wr_c            = 1'b0;
        val_c           = '0;
        lim_c           = 1'b0;
        case (act_reg)
            ACT_ENABLE: begin
                enabled_next = 1'b1;
            end
            ACT_DISABLE: begin
                wr_c            = 1'b1;
                val_c           = cur_reg;
                clear_dist      = 1'b1;
                scan_index_next = '0;
                enabled_next    = 1'b0;
            end
            ACT_TICK: begin
                case (phase_reg)
                    PH_IDLE: begin
                        if (enabled_reg) begin
                            phase_next = PH_POSITION;
                        end else if (angle_reg != angle_of(2'd0)) begin
                            phase_next = PH_PARK;
                        end
                    end
                    PH_POSITION: begin
                        move_c     = 1'b1;
                        target_c   = angle_of(idx_ext[1:0]);
                        phase_next = PH_WAIT_STOP;
                    end
                    PH_WAIT_STOP: begin
                        if (settled_reg) begin
                            phase_next = PH_PING;
                        end
                    end
                    PH_PING: begin
                        ping_c     = 1'b1;
                        phase_next = PH_WAIT_ECHO;
                    end
                    PH_WAIT_ECHO: begin
                        if (echo_reg) begin
                            store_dist = 1'b1;
                            if (scan_index_reg == LAST_IDX) begin
                                scan_index_next = '0;
                            end else begin
                                scan_index_next = scan_index_reg + 1'b1;
                            end
                            phase_next = PH_CALC;
                        end
                    end
                    PH_CALC: begin
                        // handled by the search sequence
                        phase_next = PH_REACT;
                    end
                    PH_REACT: begin
                        if (nearest_reg >= dist_max_reg) begin
                            wr_c  = 1'b1;
                            val_c = cur_reg;
                        end else if (nearest_reg < dist_min_reg && cur_reg != '0) begin
                            wr_c  = 1'b1;
                            lim_c = 1'b1;
                        end else if (nearest_reg < dist_mid_reg &&
                                     cur_reg > speed_lowest_reg) begin
                            wr_c  = 1'b1;
                            val_c = speed_lowest_reg;
                            lim_c = 1'b1;
                        end else if (cur_reg > speed_lower_reg) begin
                            wr_c  = 1'b1;
                            val_c = speed_lower_reg;
                            lim_c = 1'b1;
                        end
                        phase_next = PH_IDLE;
                    end
                    PH_PARK: begin
                        move_c     = 1'b1;
                        target_c   = angle_of(2'd0);
                        phase_next = PH_WAIT_PARK;
                    end
                    PH_WAIT_PARK: begin
                        if (settled_reg) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            default: begin
                // unused action: no change, no commands
            end
        endcase
    end

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_min_reg     <= RST_DIST_MIN;
            dist_mid_reg     <= RST_DIST_MID;
            dist_max_reg     <= RST_DIST_MAX;
            speed_lowest_reg <= RST_SPEED_LOWEST;
            speed_lower_reg  <= RST_SPEED_LOWER;
            range_max_reg    <= RST_RANGE_MAX;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DIST_MIN:     dist_min_reg     <= cfg_data;
                CFG_DIST_MID:     dist_mid_reg     <= cfg_data;
                CFG_DIST_MAX:     dist_max_reg     <= cfg_data;
                CFG_SPEED_LOWEST: speed_lowest_reg <= cfg_data;
                CFG_SPEED_LOWER:  speed_lower_reg  <= cfg_data;
                CFG_RANGE_MAX:    range_max_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // item capture and search registers, payload only
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg       <= s_action;
            settled_reg   <= s_servo_settled;
            echo_reg      <= s_echo_ready;
            echo_dist_reg <= s_echo_distance;
            angle_reg     <= s_servo_angle;
            cur_reg       <= s_current_limit;
        end
        if (cmd.scan_init) begin
            scan_cnt_reg <= '0;
            min_reg      <= range_max_reg;
        end else if (cmd.scan_step) begin
            if (dist_rd < min_reg) begin
                min_reg <= dist_rd;
            end
            scan_cnt_reg <= sts.scan_last ? '0 : scan_cnt_reg + 1'b1;
        end
    end

    // scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            scan_index_reg <= '0;
            enabled_reg    <= 1'b0;
            nearest_reg    <= '0;
            for (int i = 0; i < SCAN_POINTS; i++) begin
                dist_reg[i] <= '0;
            end
        end else if (cmd.commit) begin
            phase_reg      <= phase_next;
            scan_index_reg <= scan_index_next;
            enabled_reg    <= enabled_next;
            if (clear_dist) begin
                for (int i = 0; i < SCAN_POINTS; i++) begin
                    dist_reg[i] <= '0;
                end
            end else if (store_dist) begin
                dist_reg[scan_index_reg] <= echo_dist_reg;
            end
        end else if (cmd.scan_commit) begin
            phase_reg   <= PH_REACT;
            nearest_reg <= min_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_servo_move    <= move_c;
            m_servo_target  <= target_c;
            m_ping_request  <= ping_c;
            m_speed_write   <= wr_c;
            m_speed_value   <= val_c;
            m_speed_limited <= lim_c;
            m_nearest       <= nearest_reg;
            m_phase_now     <= phase_next;
        end else if (cmd.scan_commit) begin
            m_servo_move    <= 1'b0;
            m_servo_target  <= '0;
            m_ping_request  <= 1'b0;
            m_speed_write   <= 1'b0;
            m_speed_value   <= '0;
            m_speed_limited <= 1'b0;
            m_nearest       <= min_reg;
            m_phase_now     <= PH_REACT;
        end
    end

endmodule
